/* src/rcpwc_pkg.sv */
// rcpwc_pkg: shared types and constants for the rc pulse width capture block
// no dependencies; used by every module and interface of the block
`timescale 1ns / 1ps

package rcpwc_pkg;

   // command codes of an input transaction
   localparam logic [1:0] CMD_RISE = 2'd0;
   localparam logic [1:0] CMD_FALL = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // field widths
   localparam int CMD_W   = 2;
   localparam int CHAN_W  = 2;
   localparam int COUNT_W = 16;
   localparam int MISS_W  = 8;

   // miss counter limits
   localparam logic [MISS_W-1:0] MISS_SATURATE    = 8'hFF;
   localparam logic [MISS_W-1:0] MISS_LIMIT_RESET = 8'd10;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_STOPPED_WIDTH = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MISS_LIMIT    = 3'd4;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_REPORT
   } state_type;

   // sequencer to channel state controls
   typedef struct packed {
      logic load_item;
      logic exec_edge;
      logic sweep_step;
      logic report;
   } ctrl_type;

   // channel state to sequencer status
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             sweep_last;
   } status_type;

endpackage

/* src/rcpwc_if.sv */
// rcpwc_req_if / rcpwc_rsp_if: valid-ready channels for input and result transactions
// depends on rcpwc_pkg for field widths
`timescale 1ns / 1ps

interface rcpwc_req_if;
   logic                           valid;
   logic                           ready;
   logic [rcpwc_pkg::CMD_W-1:0]    command;
   logic [rcpwc_pkg::CHAN_W-1:0]   channel;
   logic [rcpwc_pkg::COUNT_W-1:0]  timer_count;

   modport source (output valid, command, channel, timer_count, input ready);
   modport sink   (input valid, command, channel, timer_count, output ready);
endinterface

interface rcpwc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rcpwc_pkg::CHAN_W-1:0]   report_channel;
   logic [rcpwc_pkg::COUNT_W-1:0]  pulse_width;
   logic                           new_pulse;
   logic                           failsafe_active;

   modport source (output valid, report_channel, pulse_width, new_pulse, failsafe_active,
                   input ready);
   modport sink   (input valid, report_channel, pulse_width, new_pulse, failsafe_active,
                   output ready);
endinterface

/* src/rc_pulse_width_capture_failsafe.sv */
// rc_pulse_width_capture_failsafe: pulse width capture with per-channel failsafe
// an edge transaction is executed and then reported; a tick first sweeps every channel, then is reported
// one transaction at a time: a new input is taken only after the last result is registered; the tick
// sweep walks the miss counters one channel per cycle through one shared adder
// reset: synchronous active high; clears all channel state, stopped width 0, miss limit 10
// depends on rcpwc_pkg, rcpwc_if, rcpwc_csr, rcpwc_chan_state, rcpwc_seq
`timescale 1ns / 1ps

module rc_pulse_width_capture_failsafe #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   rcpwc_req_if.sink                           req_chan,
   rcpwc_rsp_if.source                         rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rcpwc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rcpwc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rcpwc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   logic [rcpwc_pkg::COUNT_W-1:0] stopped_width;
   logic [rcpwc_pkg::MISS_W-1:0]  miss_limit;
   rcpwc_pkg::ctrl_type           ctrl;
   rcpwc_pkg::status_type         status;

   // configuration registers
   rcpwc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .stopped_width (stopped_width),
      .miss_limit    (miss_limit)
   );

   // sequencer
   rcpwc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   // channel state and shared arithmetic
   rcpwc_chan_state #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_chan_state (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_command     (req_chan.command),
      .req_channel     (req_chan.channel),
      .req_timer_count (req_chan.timer_count),
      .stopped_width   (stopped_width),
      .miss_limit      (miss_limit),
      .out_channel     (rsp_chan.report_channel),
      .out_width       (rsp_chan.pulse_width),
      .out_new_pulse   (rsp_chan.new_pulse),
      .out_failsafe    (rsp_chan.failsafe_active)
   );

`ifndef SYNTHESIS
   // a fresh measurement clears the miss count, so failsafe cannot be set with it
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.new_pulse |-> !rsp_chan.failsafe_active)
      else $error("new pulse reported together with failsafe");

   // one transaction at a time: no accept in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("input accepted while a transaction is in progress");

   // a result appears only after the sequencer left idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(!req_chan.ready))
      else $error("result raised without a transaction in progress");
`endif

endmodule

/* src/rcpwc_csr.sv */
// rcpwc_csr: apb-style configuration registers (stopped width, miss limit)
// depends on rcpwc_pkg for the register map
`timescale 1ns / 1ps

module rcpwc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rcpwc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rcpwc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rcpwc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready,
   output logic [rcpwc_pkg::COUNT_W-1:0]       stopped_width,
   output logic [rcpwc_pkg::MISS_W-1:0]        miss_limit
);

   logic [rcpwc_pkg::COUNT_W-1:0] stopped_ff, stopped_in;
   logic [rcpwc_pkg::MISS_W-1:0]  limit_ff, limit_in;
   logic                          wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // register write decode
   always_comb begin
      stopped_in = stopped_ff;
      limit_in   = limit_ff;
      if (wr_en) begin
         case (paddr)
            rcpwc_pkg::ADDR_STOPPED_WIDTH: stopped_in = pwdata[rcpwc_pkg::COUNT_W-1:0];
            rcpwc_pkg::ADDR_MISS_LIMIT:    limit_in   = pwdata[rcpwc_pkg::MISS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff <= '0;
         limit_ff   <= rcpwc_pkg::MISS_LIMIT_RESET;
      end else begin
         stopped_ff <= stopped_in;
         limit_ff   <= limit_in;
      end
   end

   // read mux
   always_comb begin
      case (paddr)
         rcpwc_pkg::ADDR_STOPPED_WIDTH: prdata = rcpwc_pkg::CSR_DATA_W'(stopped_ff);
         rcpwc_pkg::ADDR_MISS_LIMIT:    prdata = rcpwc_pkg::CSR_DATA_W'(limit_ff);
         default:                       prdata = '0;
      endcase
   end

   assign stopped_width = stopped_ff;
   assign miss_limit    = limit_ff;

endmodule

/* src/rcpwc_chan_state.sv */
// rcpwc_chan_state: per-channel state, captured transaction and the shared adder/comparator
// depends on rcpwc_pkg for types and constants
`timescale 1ns / 1ps

module rcpwc_chan_state #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rcpwc_pkg::ctrl_type                 ctrl,
   output rcpwc_pkg::status_type               status,
   input  logic [rcpwc_pkg::CMD_W-1:0]         req_command,
   input  logic [rcpwc_pkg::CHAN_W-1:0]        req_channel,
   input  logic [rcpwc_pkg::COUNT_W-1:0]       req_timer_count,
   input  logic [rcpwc_pkg::COUNT_W-1:0]       stopped_width,
   input  logic [rcpwc_pkg::MISS_W-1:0]        miss_limit,
   output logic [rcpwc_pkg::CHAN_W-1:0]        out_channel,
   output logic [rcpwc_pkg::COUNT_W-1:0]       out_width,
   output logic                                out_new_pulse,
   output logic                                out_failsafe
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

   // captured transaction
   logic [rcpwc_pkg::CMD_W-1:0]   cmd_ff;
   logic [rcpwc_pkg::CHAN_W-1:0]  chan_ff;
   logic [rcpwc_pkg::COUNT_W-1:0] count_ff;
   logic                          fresh_ff, fresh_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;

   // channel state
   logic [rcpwc_pkg::COUNT_W-1:0] start_ff [NUM_CHANNELS];
   logic [rcpwc_pkg::COUNT_W-1:0] start_in [NUM_CHANNELS];
   logic [rcpwc_pkg::COUNT_W-1:0] held_ff  [NUM_CHANNELS];
   logic [rcpwc_pkg::COUNT_W-1:0] held_in  [NUM_CHANNELS];
   logic [rcpwc_pkg::MISS_W-1:0]  miss_ff  [NUM_CHANNELS];
   logic [rcpwc_pkg::MISS_W-1:0]  miss_in  [NUM_CHANNELS];

   // result register
   logic [rcpwc_pkg::CHAN_W-1:0]  rchan_ff;
   logic [rcpwc_pkg::COUNT_W-1:0] rwidth_ff;
   logic                          rnew_ff;
   logic                          rfs_ff;

   logic                          chan_valid;
   logic [IDX_W-1:0]              chan_idx;
   logic [rcpwc_pkg::COUNT_W-1:0] sel_start;
   logic [rcpwc_pkg::COUNT_W-1:0] sel_held;
   logic [rcpwc_pkg::MISS_W-1:0]  sel_miss;
   logic [rcpwc_pkg::COUNT_W-1:0] op_a, op_b, sum;
   logic                          op_cin;
   logic [rcpwc_pkg::MISS_W-1:0]  cmp_a;
   logic                          over;

   assign chan_valid = 32'(chan_ff) < 32'(NUM_CHANNELS);
   assign chan_idx   = IDX_W'(chan_ff);

   // one entry read per cycle at the sequencer index
   assign sel_start = start_ff[idx_ff];
   assign sel_held  = held_ff[idx_ff];
   assign sel_miss  = miss_ff[idx_ff];

   // shared adder: width difference on a falling edge, saturating increment on a sweep
   always_comb begin
      if (ctrl.sweep_step) begin
         op_a   = rcpwc_pkg::COUNT_W'(sel_miss);
         op_b   = '0;
         op_cin = (sel_miss != rcpwc_pkg::MISS_SATURATE);
      end else begin
         op_a   = count_ff;
         op_b   = ~sel_start;
         op_cin = 1'b1;
      end
      sum = rcpwc_pkg::COUNT_W'(op_a + op_b + rcpwc_pkg::COUNT_W'(op_cin));
   end

   // shared limit comparator
   assign cmp_a = ctrl.sweep_step ? sum[rcpwc_pkg::MISS_W-1:0] : sel_miss;
   assign over  = cmp_a > miss_limit;

   // next state of the captured transaction and the index
   always_comb begin
      idx_in   = idx_ff;
      fresh_in = fresh_ff;
      if (ctrl.load_item) begin
         fresh_in = 1'b0;
         idx_in   = (req_command == rcpwc_pkg::CMD_TICK) ? '0 : IDX_W'(req_channel);
      end else if (ctrl.sweep_step) begin
         idx_in = (idx_ff == LAST_IDX) ? chan_idx : IDX_W'(idx_ff + 1'b1);
      end else if (ctrl.exec_edge && chan_valid && cmd_ff == rcpwc_pkg::CMD_FALL) begin
         fresh_in = 1'b1;
      end
   end

   // channel state updates
   always_comb begin
      start_in = start_ff;
      held_in  = held_ff;
      miss_in  = miss_ff;
      if (ctrl.exec_edge && chan_valid) begin
         case (cmd_ff)
            rcpwc_pkg::CMD_RISE: start_in[idx_ff] = count_ff;
            rcpwc_pkg::CMD_FALL: begin
               held_in[idx_ff] = sum;
               miss_in[idx_ff] = '0;
            end
            default: ;
         endcase
      end
      if (ctrl.sweep_step) begin
         miss_in[idx_ff] = sum[rcpwc_pkg::MISS_W-1:0];
         if (over) begin
            held_in[idx_ff] = stopped_width;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         fresh_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            start_ff[i] <= '0;
            held_ff[i]  <= '0;
            miss_ff[i]  <= '0;
         end
      end else begin
         idx_ff   <= idx_in;
         fresh_ff <= fresh_in;
         start_ff <= start_in;
         held_ff  <= held_in;
         miss_ff  <= miss_in;
      end
   end

   // transaction capture and result register
   always_ff @(posedge clock) begin
      if (ctrl.load_item) begin
         cmd_ff   <= req_command;
         chan_ff  <= req_channel;
         count_ff <= req_timer_count;
      end
      if (ctrl.report) begin
         rchan_ff  <= chan_ff;
         rwidth_ff <= chan_valid ? sel_held : '0;
         rnew_ff   <= chan_valid && fresh_ff;
         rfs_ff    <= chan_valid && over;
      end
   end

   assign status.command    = cmd_ff;
   assign status.sweep_last = (idx_ff == LAST_IDX);

   assign out_channel   = rchan_ff;
   assign out_width     = rwidth_ff;
   assign out_new_pulse = rnew_ff;
   assign out_failsafe  = rfs_ff;

endmodule

/* src/rcpwc_seq.sv */
// rcpwc_seq: sequencer that steps one transaction through execute, a sweep for ticks, and report
// depends on rcpwc_pkg for state and control types
`timescale 1ns / 1ps

module rcpwc_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rcpwc_pkg::status_type  status,
   output rcpwc_pkg::ctrl_type    ctrl
);

   rcpwc_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcpwc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and controls
   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         rcpwc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load_item = 1'b1;
               state_in       = rcpwc_pkg::ST_EXEC;
            end
         end
         rcpwc_pkg::ST_EXEC: begin
            if (status.command == rcpwc_pkg::CMD_TICK) begin
               state_in = rcpwc_pkg::ST_SWEEP;
            end else begin
               ctrl.exec_edge = 1'b1;
               state_in       = rcpwc_pkg::ST_REPORT;
            end
         end
         rcpwc_pkg::ST_SWEEP: begin
            ctrl.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = rcpwc_pkg::ST_REPORT;
            end
         end
         rcpwc_pkg::ST_REPORT: begin
            // wait until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.report  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rcpwc_pkg::ST_IDLE;
            end
         end
         default: state_in = rcpwc_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* tb/rcpwc_checker.sv */
// rcpwc_checker: predicts and checks every result transaction of the pulse width capture block
// depends on rcpwc_pkg and the rcpwc_req_if / rcpwc_rsp_if interfaces; snoops the register port
`timescale 1ns / 1ps

module rcpwc_checker #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   rcpwc_req_if                                req_mon,
   rcpwc_rsp_if                                rsp_mon,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rcpwc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rcpwc_pkg::CSR_DATA_W-1:0]    pwdata,
   input  logic                                pready,
   output int                                  mismatch_count,
   output int                                  reports_pending
);
   import rcpwc_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0]  report_channel;
      logic [COUNT_W-1:0] pulse_width;
      logic               new_pulse;
      logic               failsafe_active;
   } report_type;

   // predicted register copies and channel state
   logic [COUNT_W-1:0] stopped_width;
   logic [MISS_W-1:0]  miss_limit;
   logic [COUNT_W-1:0] rise_stamp [NUM_CHANNELS];
   logic [COUNT_W-1:0] held_width [NUM_CHANNELS];
   logic [MISS_W-1:0]  miss_count [NUM_CHANNELS];

   report_type expected_reports [$];

   initial begin
      mismatch_count  = 0;
      reports_pending = 0;
   end

   // apply one input transaction to the predicted state and build its report
   function automatic report_type capture_step(input logic [CMD_W-1:0]   cmd,
                                               input logic [CHAN_W-1:0]  ch,
                                               input logic [COUNT_W-1:0] stamp);
      report_type r;
      logic       in_range;
      in_range         = (int'(ch) < NUM_CHANNELS);
      r                = '0;
      r.report_channel = ch;
      if (cmd == CMD_TICK) begin
         // overflow tick walks every channel, even when the reported one is out of range
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (miss_count[i] != MISS_SATURATE) begin
               miss_count[i] = miss_count[i] + 1'b1;
            end
            if (miss_count[i] > miss_limit) begin
               held_width[i] = stopped_width;
            end
         end
      end else if (in_range && cmd == CMD_RISE) begin
         rise_stamp[ch] = stamp;
      end else if (in_range && cmd == CMD_FALL) begin
         held_width[ch] = stamp - rise_stamp[ch];
         miss_count[ch] = '0;
         r.new_pulse    = 1'b1;
      end
      if (in_range) begin
         r.pulse_width     = held_width[ch];
         r.failsafe_active = (miss_count[ch] > miss_limit);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         stopped_width = '0;
         miss_limit    = MISS_LIMIT_RESET;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            rise_stamp[i] = '0;
            held_width[i] = '0;
            miss_count[i] = '0;
         end
         expected_reports.delete();
      end else begin
         // register writes seen on the configuration port
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               ADDR_STOPPED_WIDTH: stopped_width = pwdata[COUNT_W-1:0];
               ADDR_MISS_LIMIT:    miss_limit    = pwdata[MISS_W-1:0];
               default: ;
            endcase
         end

         // accepted input transaction
         if (req_mon.valid && req_mon.ready) begin
            expected_reports.push_back(capture_step(req_mon.command, req_mon.channel,
                                                    req_mon.timer_count));
         end

         // accepted result transaction against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_reports.size() == 0) begin
               $error("result transaction with no report expected");
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_mon.report_channel !== want.report_channel) begin
                  $error("report_channel: expected %0d, actual %0d",
                         want.report_channel, rsp_mon.report_channel);
                  mismatch_count++;
               end
               if (rsp_mon.pulse_width !== want.pulse_width) begin
                  $error("pulse_width: expected %0d, actual %0d",
                         want.pulse_width, rsp_mon.pulse_width);
                  mismatch_count++;
               end
               if (rsp_mon.new_pulse !== want.new_pulse) begin
                  $error("new_pulse: expected %0d, actual %0d",
                         want.new_pulse, rsp_mon.new_pulse);
                  mismatch_count++;
               end
               if (rsp_mon.failsafe_active !== want.failsafe_active) begin
                  $error("failsafe_active: expected %0d, actual %0d",
                         want.failsafe_active, rsp_mon.failsafe_active);
                  mismatch_count++;
               end
            end
         end
      end
      reports_pending = expected_reports.size();
   end

endmodule

/* tb/rc_pulse_width_capture_failsafe_tb.sv */
// rc_pulse_width_capture_failsafe_tb: stimulus, register setup and verdict for the capture block
// depends on rcpwc_pkg, rcpwc_if, the block itself and rcpwc_checker
`timescale 1ns / 1ps

module rc_pulse_width_capture_failsafe_tb;
   import rcpwc_pkg::*;

   localparam int         NUM_CHANNELS = 4;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatch_count;
   int reports_pending;
   int items_sent = 0;
   int cycle_count = 0;
   bit send_idle = 1'b0;
   bit recv_idle = 1'b0;

   rcpwc_req_if req_chan ();
   rcpwc_rsp_if rsp_chan ();

   rc_pulse_width_capture_failsafe #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   rcpwc_checker #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .mismatch_count  (mismatch_count),
      .reports_pending (reports_pending)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rc_pulse_width_capture_failsafe test failed");
         $finish;
      end
   end

   function automatic int unsigned idle_gap(input bit enabled);
      return enabled ? $urandom_range(0, 15) : 0;
   endfunction

   // result side: random stall before each transaction
   initial begin
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = idle_gap(recv_idle);
         if (stall != 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   // one input transaction, called and returning at a falling edge
   task automatic send_item(input logic [1:0] cmd, input logic [1:0] ch,
                            input logic [15:0] stamp);
      int unsigned gap;
      gap = idle_gap(send_idle);
      if (gap != 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.command     = cmd;
      req_chan.channel     = ch;
      req_chan.timer_count = stamp;
      req_chan.valid       = 1'b1;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
      items_sent++;
   endtask

   // register write: setup then access phase
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // hold off until every result is back and the tick sweep has surely finished
   task automatic drain_results();
      req_chan.valid = 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (NUM_CHANNELS + 8) @(negedge clock);
   endtask

   // random traffic: rise/fall pairs with random content plus ticks and noise, mostly pairs unless tick-heavy;
   // tick-heavy mode never closes a pulse on the last channel so its counter saturates
   task automatic random_traffic(input int count, input bit tick_heavy);
      int          stop_at;
      int          pick;
      int          rounds;
      logic [1:0]  ch;
      logic [1:0]  cmd;
      logic [15:0] rise_at;
      logic [15:0] width;
      stop_at = items_sent + count;
      rounds  = 0;
      while (items_sent < stop_at) begin
         if (rounds % 40 == 0) begin
            send_idle = ($urandom_range(0, 2) != 0);
            recv_idle = ($urandom_range(0, 2) != 0);
         end
         rounds++;
         pick = int'($urandom_range(0, 9));
         if (tick_heavy ? (pick < 2) : (pick < 6)) begin
            ch      = tick_heavy ? 2'($urandom_range(0, NUM_CHANNELS - 2))
                                 : 2'($urandom_range(0, NUM_CHANNELS - 1));
            rise_at = 16'($urandom);
            width   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'(1000 + $urandom_range(0, 1000));
            send_item(CMD_RISE, ch, rise_at);
            if ($urandom_range(0, 2) == 0) begin
               send_item(CMD_TICK, 2'($urandom_range(0, 3)), 16'($urandom));
            end
            send_item(CMD_FALL, ch, rise_at + width);
         end else if (tick_heavy ? (pick < 9) : (pick < 8)) begin
            send_item(CMD_TICK, 2'($urandom_range(0, 3)), 16'($urandom));
         end else begin
            cmd = 2'($urandom_range(0, 3));
            ch  = 2'($urandom_range(0, 3));
            if (tick_heavy && cmd == CMD_FALL && ch == 2'(NUM_CHANNELS - 1)) begin
               ch = 2'd0;
            end
            send_item(cmd, ch, 16'($urandom));
         end
      end
   endtask

   // main sequence
   initial begin
      req_chan.valid       = 1'b0;
      req_chan.command     = CMD_RISE;
      req_chan.channel     = '0;
      req_chan.timer_count = '0;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = ADDR_STOPPED_WIDTH;
      pwdata               = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: timer extremes, wraparound, zero width, unused command, fall without rise
      send_item(CMD_RISE, 2'd0, 16'h0000);
      send_item(CMD_FALL, 2'd0, 16'hFFFF);
      send_item(CMD_RISE, 2'd1, 16'hFFFF);
      send_item(CMD_FALL, 2'd1, 16'h0000);
      send_item(CMD_RISE, 2'd2, 16'd1500);
      send_item(CMD_FALL, 2'd2, 16'd1500);
      send_item(CMD_RISE, 2'd3, 16'hA5A5);
      send_item(CMD_FALL, 2'd3, 16'hA5A4);
      send_item(CMD_UNUSED, 2'd2, 16'hFFFF);
      send_item(CMD_UNUSED, 2'd3, 16'h0000);
      send_item(CMD_FALL, 2'd0, 16'h1234);
      // ticks past the reset limit engage failsafe on every channel
      for (int i = 0; i < 11; i++) begin
         send_item(CMD_TICK, 2'(i), 16'h5A5A);
      end
      send_item(CMD_UNUSED, 2'd1, 16'h0F0F);
      send_item(CMD_RISE, 2'd1, 16'd100);
      send_item(CMD_FALL, 2'd1, 16'd1600);

      // all-ones stopped width, failsafe on the first missed tick
      drain_results();
      csr_write(ADDR_STOPPED_WIDTH, 32'h0000_FFFF);
      csr_write(ADDR_MISS_LIMIT, 32'd0);
      random_traffic(200, 1'b0);

      // limit just below saturation, long tick runs drive the idle channel's miss count up
      drain_results();
      csr_write(ADDR_STOPPED_WIDTH, 32'($urandom_range(1, 16'hFFFE)));
      csr_write(ADDR_MISS_LIMIT, 32'd254);
      random_traffic(330, 1'b1);

      // limit at the saturation value: failsafe can never engage
      drain_results();
      csr_write(ADDR_STOPPED_WIDTH, 32'd0);
      csr_write(ADDR_MISS_LIMIT, 32'd255);
      random_traffic(260, 1'b1);

      // small limit so failsafe comes and goes
      drain_results();
      csr_write(ADDR_STOPPED_WIDTH, 32'($urandom_range(0, 16'hFFFF)));
      csr_write(ADDR_MISS_LIMIT, 32'($urandom_range(1, 6)));
      random_traffic(280, 1'b0);

      drain_results();
      if (mismatch_count == 0) begin
         $display("rc_pulse_width_capture_failsafe test passed");
      end else begin
         $display("rc_pulse_width_capture_failsafe test failed");
      end
      $finish;
   end

endmodule
